@@ hw/rtl/sorted_priority_queue_defines.svh @@
// ----------------------------------------------------------------------------
// sorted_priority_queue_defines.svh
// Assertion macros shared by the priority queue files.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants shared by the sorted priority queue modules.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Defaults for the top-level parameters
  localparam int DEPTH_DEF      = 16;
  localparam int PRIO_WIDTH_DEF = 8;

  // Fixed field widths
  localparam int VALUE_W  = 32;
  localparam int PRIO_IN_W = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Request codes
  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // Controller states
  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // Datapath operations
  typedef enum logic [2:0] {
    OP_NONE,
    OP_INSERT,
    OP_REMOVE,
    OP_OVERFLOW,
    OP_UNDERFLOW
  } op_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    op_t  op;
  } spq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic req_deq;
    logic full;
    logic empty;
  } spq_stat_t;

endpackage

@@ hw/rtl/spq_ctrl.sv @@
// ----------------------------------------------------------------------------
// spq_ctrl
// Request sequencer: takes a beat, then picks the datapath operation from the
// latched request type and the full/empty flags.
// ----------------------------------------------------------------------------
module spq_ctrl
  import spq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  spq_stat_t stat,
  output spq_cmd_t  cmd
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    busy     = 1'b0;
    cmd.load = 1'b0;
    cmd.op   = OP_NONE;
    case (state_r)
      S_IDLE: begin
        cmd.load = start;
      end
      S_EXEC: begin
        busy = 1'b1;
        if (stat.req_deq) begin
          cmd.op = stat.empty ? OP_UNDERFLOW : OP_REMOVE;
        end else begin
          cmd.op = stat.full ? OP_OVERFLOW : OP_INSERT;
        end
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

@@ hw/rtl/spq_dp.sv @@
// ----------------------------------------------------------------------------
// spq_dp
// Datapath: request latch, a row of sorted entry cells that insert or pop all
// at once, the entry count and the result register.
// ----------------------------------------------------------------------------
module spq_dp
  import spq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int PRIO_WIDTH = PRIO_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  spq_cmd_t                   cmd,
  output spq_stat_t                  stat,
  input  logic                       in_req_type,
  input  logic signed [VALUE_W-1:0]  in_value,
  input  logic [PRIO_IN_W-1:0]       in_priority_req,
  output logic                       out_valid,
  output logic signed [VALUE_W-1:0]  out_value,
  output logic [STATUS_W-1:0]        out_status,
  output logic [COUNT_W-1:0]         out_count
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  // Latched request
  logic                  req_r;
  logic [VALUE_W-1:0]    val_in_r;
  logic [PRIO_WIDTH-1:0] pri_in_r;

  // Entry cells, head at slot 0
  logic [VALUE_W-1:0]    val_r   [DEPTH];
  logic [VALUE_W-1:0]    val_nxt [DEPTH];
  logic [PRIO_WIDTH-1:0] pri_r   [DEPTH];
  logic [PRIO_WIDTH-1:0] pri_nxt [DEPTH];
  logic [CNT_W-1:0]      count_r, count_nxt;

  // Result register
  logic                  res_valid_r, res_valid_nxt;
  logic [VALUE_W-1:0]    res_val_r, res_val_nxt;
  status_t               res_st_r, res_st_nxt;
  logic [COUNT_W-1:0]    res_cnt_r, res_cnt_nxt;

  // Per-cell: entry is live and ranks below the new item
  logic [DEPTH-1:0] lt;

  // Request latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r    <= in_req_type;
      val_in_r <= in_value;
      pri_in_r <= PRIO_WIDTH'(in_priority_req);
    end
  end

  assign stat.req_deq = (req_r == REQ_DEQ);
  assign stat.full    = (count_r == CNT_W'(DEPTH));
  assign stat.empty   = (count_r == '0);

  // Compare every cell against the new priority
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      lt[i] = (CNT_W'(i) < count_r) && (pri_r[i] < pri_in_r);
    end
  end

  // Cell updates and result
  always_comb begin
    val_nxt       = val_r;
    pri_nxt       = pri_r;
    count_nxt     = count_r;
    res_valid_nxt = 1'b0;
    res_val_nxt   = res_val_r;
    res_st_nxt    = res_st_r;
    res_cnt_nxt   = res_cnt_r;
    case (cmd.op)
      OP_INSERT: begin
        // slot 0 either keeps its entry or takes the new one
        if (lt[0] || count_r == '0) begin
          val_nxt[0] = val_in_r;
          pri_nxt[0] = pri_in_r;
        end
        // other slots: keep, shift down from above, or take the new item
        for (int i = 1; i < DEPTH; i++) begin
          if (lt[i] || CNT_W'(i) == count_r) begin
            if (lt[i-1]) begin
              val_nxt[i] = val_r[i-1];
              pri_nxt[i] = pri_r[i-1];
            end else begin
              val_nxt[i] = val_in_r;
              pri_nxt[i] = pri_in_r;
            end
          end
        end
        count_nxt     = count_r + CNT_W'(1);
        res_valid_nxt = 1'b1;
        res_val_nxt   = '0;
        res_st_nxt    = ST_OK;
        res_cnt_nxt   = COUNT_W'(count_r + CNT_W'(1));
      end
      OP_REMOVE: begin
        // pop the head, everything moves up one slot
        for (int i = 0; i < DEPTH - 1; i++) begin
          val_nxt[i] = val_r[i+1];
          pri_nxt[i] = pri_r[i+1];
        end
        count_nxt     = count_r - CNT_W'(1);
        res_valid_nxt = 1'b1;
        res_val_nxt   = val_r[0];
        res_st_nxt    = ST_OK;
        res_cnt_nxt   = COUNT_W'(count_r - CNT_W'(1));
      end
      OP_OVERFLOW: begin
        res_valid_nxt = 1'b1;
        res_val_nxt   = '0;
        res_st_nxt    = ST_OVERFLOW;
        res_cnt_nxt   = COUNT_W'(count_r);
      end
      OP_UNDERFLOW: begin
        res_valid_nxt = 1'b1;
        res_val_nxt   = '1;
        res_st_nxt    = ST_UNDERFLOW;
        res_cnt_nxt   = COUNT_W'(count_r);
      end
      default: begin
        res_valid_nxt = 1'b0;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // Payload state
  always_ff @(posedge clk) begin
    val_r     <= val_nxt;
    pri_r     <= pri_nxt;
    res_val_r <= res_val_nxt;
    res_st_r  <= res_st_nxt;
    res_cnt_r <= res_cnt_nxt;
  end

  assign out_valid  = res_valid_r;
  assign out_value  = res_val_r;
  assign out_status = res_st_r;
  assign out_count  = res_cnt_r;

endmodule

@@ hw/rtl/sorted_priority_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue, entries kept sorted by descending priority; equal
// priorities leave in arrival order. One result beat per request.
// ----------------------------------------------------------------------------
//   channel  | handshake             | payload
//   ---------+-----------------------+-----------------------------------------
//   request  | start / busy          | in_req_type, in_value, in_priority_req
//   result   | out_valid (strobe)    | out_value, out_status, out_count
//
// A request is latched in the accept cycle; the next cycle updates the whole
// row of entry cells at once and loads the result register.
// The result strobe is high for one cycle, in which the next request may
// already be accepted; no new request is taken while busy.
// Synchronous active-low reset empties the queue; no clearing pass is needed.
// The receiver cannot stall the result.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_defines.svh"

module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int PRIO_WIDTH = PRIO_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_req_type,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic [PRIO_IN_W-1:0]      in_priority_req,
  output logic                      out_valid,
  output logic signed [VALUE_W-1:0] out_value,
  output logic [STATUS_W-1:0]       out_status,
  output logic [COUNT_W-1:0]        out_count
);

  spq_cmd_t  cmd;
  spq_stat_t stat;

  spq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  spq_dp #(
    .DEPTH      (DEPTH),
    .PRIO_WIDTH (PRIO_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_req_type     (in_req_type),
    .in_value        (in_value),
    .in_priority_req (in_priority_req),
    .out_valid       (out_valid),
    .out_value       (out_value),
    .out_status      (out_status),
    .out_count       (out_count)
  );

  // Checks
  `SPQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
  `SPQ_ASSERT_NEXT(a_exec_one, busy, !busy && out_valid, "execute cycle did not yield result")
  `SPQ_ASSERT_NOW(a_strobe_idle, out_valid, !busy, "result strobe while busy")
  `SPQ_ASSERT_NOW(a_uflow_val, out_valid && out_status == ST_UNDERFLOW, out_value == -1,
                  "underflow value not -1")

endmodule
